/* hw/rtl/lfu_cache_table_macros.svh */
// assertion helpers for the lfu cache table
`ifndef LFU_CACHE_TABLE_MACROS_SVH
`define LFU_CACHE_TABLE_MACROS_SVH

// property must hold at every clock edge outside reset
`define LCT_CHECK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("lfu_cache_table check failed");

// condition must never be true outside reset
`define LCT_NEVER(label, cond) \
   `LCT_CHECK(label, !(cond))

`endif

/* hw/rtl/lct_pkg.sv */
package lct_pkg;

   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;
   localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W     = IDX_W;
   localparam int OCC_W      = $clog2(ENTRIES + 1);
   localparam int CAP_W      = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   localparam logic [1:0] OP_NONE   = 2'd0;
   localparam logic [1:0] OP_TOUCH  = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;

   typedef struct packed {
      logic               func;
      logic [31:0]        key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] read_value;
      logic               evicted;
      logic [31:0]        evicted_key;
   } rsp_type;

   // best eviction candidate seen so far along the chain
   typedef struct packed {
      logic                  ok;
      logic [COUNT_BITS-1:0] cnt;
      logic [RANK_W-1:0]     rank;
      logic [IDX_W-1:0]      idx;
      logic [31:0]           key;
   } cand_type;

   // update broadcast to every cell
   typedef struct packed {
      logic [1:0]        kind;
      logic [IDX_W-1:0]  slot;
      logic [RANK_W-1:0] rank;
      logic              evict;
      logic              wr_data;
      logic [31:0]       key;
      logic [31:0]       value;
   } op_type;

endpackage

/* hw/rtl/lct_cell.sv */
module lct_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [lct_pkg::IDX_W-1:0] idx,
   input  lct_pkg::op_type      op,
   input  logic [31:0]          look_key,
   input  lct_pkg::cand_type    cand_in,
   output lct_pkg::cand_type    cand_out,
   output logic                 valid,
   output logic                 match,
   output logic [31:0]          data,
   output logic [lct_pkg::RANK_W-1:0] rank
);
   import lct_pkg::*;

   logic                  valid_ff, valid_in;
   logic [31:0]           key_ff, key_in;
   logic [31:0]           data_ff, data_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RANK_W-1:0]     rank_ff, rank_in;
   cand_type              cand_ff, cand_in_nxt;
   logic                  mine;

   assign mine = (op.slot == idx);

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      cnt_in   = cnt_ff;
      rank_in  = rank_ff;
      case (op.kind)
         OP_TOUCH: begin
            if (mine) begin
               rank_in = '0;
               if (cnt_ff != '1) cnt_in = cnt_ff + 1'b1;
               if (op.wr_data) data_in = op.value;
            end else if (valid_ff && rank_ff < op.rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (mine) begin
               valid_in = 1'b1;
               key_in   = op.key;
               data_in  = op.value;
               cnt_in   = COUNT_BITS'(1);
               rank_in  = '0;
            end else if (valid_ff && (!op.evict || rank_ff < op.rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // keep the lower count, the older entry on equal counts
   always_comb begin
      cand_in_nxt = cand_in;
      if (valid_ff && (!cand_in.ok || cnt_ff < cand_in.cnt ||
          (cnt_ff == cand_in.cnt && rank_ff > cand_in.rank))) begin
         cand_in_nxt.ok   = 1'b1;
         cand_in_nxt.cnt  = cnt_ff;
         cand_in_nxt.rank = rank_ff;
         cand_in_nxt.idx  = idx;
         cand_in_nxt.key  = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         cand_ff.ok <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         cand_ff.ok <= cand_in_nxt.ok;
      end
      key_ff       <= key_in;
      data_ff      <= data_in;
      cnt_ff       <= cnt_in;
      rank_ff      <= rank_in;
      cand_ff.cnt  <= cand_in_nxt.cnt;
      cand_ff.rank <= cand_in_nxt.rank;
      cand_ff.idx  <= cand_in_nxt.idx;
      cand_ff.key  <= cand_in_nxt.key;
   end

   assign cand_out = cand_ff;
   assign valid    = valid_ff;
   assign match    = valid_ff && (key_ff == look_key);
   assign data     = data_ff;
   assign rank     = rank_ff;

endmodule

/* hw/rtl/lfu_cache_table.sv */
// lfu cache table: a key/value store of up to ENTRIES slots with least-frequently-used
// replacement, least recently used on equal counts. Each slot is one cell of a chain; keys
// are compared in all cells at once. A get or a put that hits, or a put that finds a free
// slot, goes through accept, lookup and result register steps. A put of a new key into a full
// table also scans while the eviction candidate ripples through the registered cell chain
// one cell per cycle. capacity must be written through csr_we/csr_wdata only while the
// block is idle; the block does not enforce this. Values above ENTRIES act as ENTRIES,
// zero makes puts do nothing. Slot valid bits clear in the reset cycle itself.
module lfu_cache_table (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lct_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lct_pkg::rsp_type     rsp_data,
   input  logic                 csr_we,
   input  logic [lct_pkg::CAP_W-1:0] csr_wdata
);
   import lct_pkg::*;

   `include "lfu_cache_table_macros.svh"

   // sequencer codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_POST = 2'd3;
   localparam int SCAN_W = $clog2(ENTRIES + 1);

   logic [1:0]        state_ff, state_in;
   logic [CAP_W-1:0]  cap_ff;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   req_type           req_ff;
   rsp_type           pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   op_type            op;

   // cell chain
   cand_type          chain [ENTRIES+1];
   logic [ENTRIES-1:0] valid_vec, match_vec;
   logic [31:0]       data_vec [ENTRIES];
   logic [RANK_W-1:0] rank_vec [ENTRIES];

   assign chain[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .idx      (IDX_W'(i)),
         .op       (op),
         .look_key (req_ff.key),
         .cand_in  (chain[i]),
         .cand_out (chain[i+1]),
         .valid    (valid_vec[i]),
         .match    (match_vec[i]),
         .data     (data_vec[i]),
         .rank     (rank_vec[i])
      );
   end

   // hit lookup: keys are unique among valid slots, so at most one match bit is set
   logic              hit_any;
   logic [IDX_W-1:0]  hit_idx;
   logic [31:0]       hit_data;
   logic [RANK_W-1:0] hit_rank;
   logic [IDX_W-1:0]  free_idx;
   logic              table_full;
   logic              cap_zero;

   always_comb begin
      hit_idx  = '0;
      hit_data = '0;
      hit_rank = '0;
      free_idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_vec[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_data = hit_data | data_vec[i];
            hit_rank = hit_rank | rank_vec[i];
         end
      end
      // lowest-numbered free slot
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_vec[i]) free_idx = IDX_W'(i);
      end
   end

   assign hit_any  = |match_vec;
   assign cap_zero = (cap_ff == '0);
   // capacity above the slot count acts as the slot count
   assign table_full = (32'(cap_ff) >= 32'(ENTRIES)) ? (32'(occ_ff) >= 32'(ENTRIES))
                                                     : (32'(occ_ff) >= 32'(cap_ff));

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      op           = '0;
      op.kind      = OP_NONE;
      op.key       = req_ff.key;
      op.value     = req_ff.value;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOOK;
         end
         S_LOOK: begin
            pend_in  = '0;
            state_in = S_POST;
            if (req_ff.func == FUNC_GET) begin
               if (hit_any) begin
                  pend_in.found      = 1'b1;
                  pend_in.read_value = hit_data;
                  op.kind            = OP_TOUCH;
                  op.slot            = hit_idx;
                  op.rank            = hit_rank;
               end
            end else if (!cap_zero) begin
               if (hit_any) begin
                  pend_in.found = 1'b1;
                  op.kind       = OP_TOUCH;
                  op.slot       = hit_idx;
                  op.rank       = hit_rank;
                  op.wr_data    = 1'b1;
               end else if (table_full) begin
                  // wait for the candidate to reach the chain end
                  scan_in  = '0;
                  state_in = S_SCAN;
               end else begin
                  op.kind = OP_INSERT;
                  op.slot = free_idx;
                  occ_in  = occ_ff + 1'b1;
               end
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (32'(scan_ff) == 32'(ENTRIES - 1)) begin
               pend_in.evicted     = 1'b1;
               pend_in.evicted_key = chain[ENTRIES].key;
               op.kind             = OP_INSERT;
               op.slot             = chain[ENTRIES].idx;
               op.rank             = chain[ENTRIES].rank;
               op.evict            = 1'b1;
               state_in            = S_POST;
            end
         end
         S_POST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) cap_ff <= csr_wdata;
      end
      pend_ff <= pend_in;
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_POST && (!rsp_valid_ff || rsp_ready)) rsp_ff <= pend_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // fill count tracks the valid bits
   `LCT_CHECK(a_occ_matches_valid, ($countones(valid_vec) == int'(occ_ff)))
   // at most one slot holds a given key
   `LCT_CHECK(a_match_onehot, $onehot0(match_vec))
   // a result is never overwritten while waiting
   `LCT_CHECK(a_rsp_hold, (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))

endmodule

/* sim/tb_lfu_cache_table.sv */
module tb_lfu_cache_table;
   timeunit 1ns;
   timeprecision 1ps;
   import lct_pkg::*;

   localparam int COUNT_MAX  = (1 << COUNT_BITS) - 1;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   lfu_cache_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the table, updated as each request transfers
   logic        slot_valid [ENTRIES];
   logic [31:0] slot_key [ENTRIES];
   logic [31:0] slot_data [ENTRIES];
   int          slot_count [ENTRIES];
   int          slot_rank [ENTRIES];
   int          fill;
   int          cap_reg;

   rsp_type pending_rsp [$];
   int  mismatches = 0;
   int  n_sent = 0, n_rsp = 0, n_hits = 0, n_evicts = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;   // no idling on either side while set
   bit  timed_out = 1'b0;

   // recently used keys so random traffic hits often
   logic [31:0] key_pool [$];

   function automatic void bump_slot(int s);
      for (int i = 0; i < ENTRIES; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
      slot_rank[s] = 0;
      if (slot_count[s] < COUNT_MAX) slot_count[s]++;
   endfunction

   function automatic rsp_type cache_predict(req_type r);
      rsp_type o;
      int hit, cap, v, slot, rk;
      o = '0;
      hit = -1;
      cap = (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
      for (int i = 0; i < ENTRIES; i++)
         if (hit < 0 && slot_valid[i] && slot_key[i] == r.key) hit = i;
      if (r.func == FUNC_GET) begin
         if (hit >= 0) begin
            o.found = 1'b1;
            o.read_value = slot_data[hit];
            bump_slot(hit);
         end
      end else if (cap != 0) begin
         if (hit >= 0) begin
            o.found = 1'b1;
            slot_data[hit] = r.value;
            bump_slot(hit);
         end else begin
            slot = -1;
            if (fill >= cap) begin
               v = -1;
               for (int i = 0; i < ENTRIES; i++)
                  if (slot_valid[i] && (v < 0 || slot_count[i] < slot_count[v] ||
                      (slot_count[i] == slot_count[v] && slot_rank[i] > slot_rank[v])))
                     v = i;
               if (v >= 0) begin
                  rk = slot_rank[v];
                  o.evicted = 1'b1;
                  o.evicted_key = slot_key[v];
                  slot_valid[v] = 1'b0;
                  fill--;
                  for (int i = 0; i < ENTRIES; i++)
                     if (slot_valid[i] && slot_rank[i] > rk) slot_rank[i]--;
                  slot = v;
               end
            end
            if (slot < 0)
               for (int i = ENTRIES - 1; i >= 0; i--)
                  if (!slot_valid[i]) slot = i;
            if (slot >= 0) begin
               for (int i = 0; i < ENTRIES; i++)
                  if (slot_valid[i]) slot_rank[i]++;
               slot_valid[slot] = 1'b1;
               slot_key[slot] = r.key;
               slot_data[slot] = r.value;
               slot_count[slot] = 1;
               slot_rank[slot] = 0;
               fill++;
            end
         end
      end
      return o;
   endfunction

   // one request transfer; valid stays up with a stable payload until taken
   task automatic send_req(logic f, logic [31:0] k, logic [31:0] v);
      req_type r;
      r.func = f;
      r.key = k;
      r.value = v;
      // valid drops only while idling, so back-to-back items keep it high
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_rsp.push_back(cache_predict(r));
      n_sent++;
      key_pool.push_back(k);
      if (key_pool.size() > 24) void'(key_pool.pop_front());
   endtask

   // wait until every expected response is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && !timed_out) @(posedge clock);
      repeat (ENTRIES + 8) @(posedge clock);
   endtask

   task automatic set_capacity(int c);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= c[CAP_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cap_reg = c;
   endtask

   // response side: random stall, compare each transfer with the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               mismatches++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (exp_rsp.found !== rsp_data.found) begin
                  $display("%0t: found exp %0b got %0b", $time, exp_rsp.found, rsp_data.found);
                  mismatches++;
               end
               if (exp_rsp.read_value !== rsp_data.read_value) begin
                  $display("%0t: read_value exp %h got %h", $time,
                           exp_rsp.read_value, rsp_data.read_value);
                  mismatches++;
               end
               if (exp_rsp.evicted !== rsp_data.evicted) begin
                  $display("%0t: evicted exp %0b got %0b", $time,
                           exp_rsp.evicted, rsp_data.evicted);
                  mismatches++;
               end
               if (exp_rsp.evicted_key !== rsp_data.evicted_key) begin
                  $display("%0t: evicted_key exp %h got %h", $time,
                           exp_rsp.evicted_key, rsp_data.evicted_key);
                  mismatches++;
               end
               if (exp_rsp.found) n_hits++;
               if (exp_rsp.evicted) n_evicts++;
            end
         end
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 10);
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IDLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog expired at %0t", $time);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // directed: extreme keys and values, both operations, hit and miss
   task automatic test_basic();
      send_req(FUNC_GET, 32'h0, 32'h0);
      send_req(FUNC_PUT, 32'h0, 32'h8000_0000);
      send_req(FUNC_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_req(FUNC_GET, 32'h0, 32'h1234_5678);
      send_req(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_req(FUNC_PUT, 32'h0, 32'hFFFF_FFFF);   // put hit: found, no data
      send_req(FUNC_GET, 32'h0, 32'h0);
      send_req(FUNC_GET, 32'h5555_AAAA, 32'h0);   // miss
   endtask

   // small capacity: count ordering, reuse of the evicted slot
   task automatic test_eviction();
      set_capacity(2);
      send_req(FUNC_PUT, 32'hA, 32'h1);    // table already holds two: evicts
      send_req(FUNC_PUT, 32'hB, 32'h2);
      send_req(FUNC_GET, 32'hA, 32'h0);
      send_req(FUNC_PUT, 32'hC, 32'h3);    // evicts B, lower count
      send_req(FUNC_PUT, 32'hD, 32'h4);    // evicts C, lower count
      send_req(FUNC_GET, 32'hA, 32'h0);
   endtask

   // capacity 0 ignores puts but gets are still answered; above ENTRIES clamps
   task automatic test_capacity_edges();
      set_capacity(0);
      send_req(FUNC_PUT, 32'hE, 32'h5);
      send_req(FUNC_GET, 32'hA, 32'h0);
      send_req(FUNC_GET, 32'hE, 32'h0);
      set_capacity(31);
      for (int i = 0; i < ENTRIES + 2; i++) send_req(FUNC_PUT, 32'h100 + i, i);
      // lower below the fill level: each new key evicts exactly one
      set_capacity(3);
      send_req(FUNC_PUT, 32'h200, 32'h1);
      send_req(FUNC_PUT, 32'h201, 32'h2);
   endtask

   // hammer one key to raise its count; the 16-bit count does not reach saturation here
   task automatic test_saturation();
      set_capacity(1);
      send_req(FUNC_PUT, 32'h77, 32'h1);
      calm = 1'b1;
      for (int i = 0; i < 40; i++) send_req(FUNC_GET, 32'h77, 32'h0);
      calm = 1'b0;
      send_req(FUNC_PUT, 32'h78, 32'h2);
   endtask

   task automatic test_random(int n);
      logic [31:0] k, v;
      int caps [6] = '{1, 3, 16, 5, 31, 8};
      for (int i = 0; i < n; i++) begin
         if (i % 300 == 0) set_capacity(caps[(i / 300) % 6]);
         calm = (i >= 900 && i < 1150);
         v = $urandom();
         if (key_pool.size() != 0 && $urandom_range(99) < 65)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
         else if ($urandom_range(9) == 0)
            k = $urandom();
         else
            k = $urandom_range(40);
         send_req(1'($urandom_range(1)), k, v);
      end
      calm = 1'b0;
   endtask

   initial begin
      cap_reg = CAP_RESET;
      fill = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i] = '0;
         slot_data[i] = '0;
         slot_count[i] = 0;
         slot_rank[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (ENTRIES + 4) @(posedge clock);
      test_basic();
      test_eviction();
      test_capacity_edges();
      test_saturation();
      test_random(1850);
      drain();
      $display("sent %0d requests, %0d responses: %0d hits, %0d evictions",
               n_sent, n_rsp, n_hits, n_evicts);
      $display("capacities 0 to 31 covered, including shrink below the fill level");
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
